>>> rtl/core/sc_pkg.sv
package sc_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FILL_W  = 5;
  localparam int STEP_W  = $clog2(DATA_W + 1);
  localparam int QDEPTH  = 2;
  localparam int QADDR_W = 1;
  localparam int QCNT_W  = 2;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [QADDR_W-1:0] qaddr_t;
  typedef logic [QCNT_W-1:0]  qcnt_t;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_ADD  = 3'd2,
    ACT_SUB  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_MUL  = 3'd5,
    ACT_PEEK = 3'd6,
    ACT_DUMP = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    K_PUSH  = 3'd0,
    K_POP   = 3'd1,
    K_ARITH = 3'd2,
    K_PEEK  = 3'd3,
    K_DUMP  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_DIV = 2'd2,
    OP_MUL = 2'd3
  } op_t;

  typedef struct packed {
    kind_t kind;
    op_t   op;
    data_t operand;
  } cmd_t;

endpackage

>>> rtl/core/sc_if.sv
interface sc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] operand;

  modport source (output valid, action, operand, input ready);
  modport sink (input valid, action, operand, output ready);
endinterface

interface sc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] result_value;
  logic [4:0]         fill_level;
  logic               last;

  modport source (output valid, status, result_value, fill_level, last, input ready);
  modport sink (input valid, status, result_value, fill_level, last, output ready);
endinterface

>>> rtl/core/sc_ram.sv
module sc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/sc_div.sv
module sc_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sc_pkg::data_t dividend,
  input  sc_pkg::data_t divisor,
  output logic          done,
  output sc_pkg::data_t quotient
);

  logic          busy_r;
  logic          done_r;
  sc_pkg::step_t step_r;
  sc_pkg::data_t rem_r;
  sc_pkg::data_t quo_r;
  sc_pkg::data_t mb_r;
  logic          neg_r;

  logic                      na;
  logic                      nb;
  logic [sc_pkg::DATA_W:0]   rem_sh;
  logic [sc_pkg::DATA_W:0]   diff;

  assign na = dividend[sc_pkg::DATA_W-1];
  assign nb = divisor[sc_pkg::DATA_W-1];
  assign rem_sh = {rem_r, quo_r[sc_pkg::DATA_W-1]};
  assign diff = rem_sh - {1'b0, mb_r};

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == sc_pkg::step_t'(1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= sc_pkg::step_t'(sc_pkg::DATA_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == sc_pkg::step_t'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= na ? (sc_pkg::data_t'(0) - dividend) : dividend;
      mb_r  <= nb ? (sc_pkg::data_t'(0) - divisor) : divisor;
      neg_r <= na ^ nb;
    end else if (busy_r) begin
      if (!diff[sc_pkg::DATA_W]) begin
        rem_r <= diff[sc_pkg::DATA_W-1:0];
        quo_r <= {quo_r[sc_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[sc_pkg::DATA_W-1:0];
        quo_r <= {quo_r[sc_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quotient = neg_r ? (sc_pkg::data_t'(0) - quo_r) : quo_r;

endmodule

>>> rtl/core/sc_front.sv
module sc_front (
  input  logic         clk,
  input  logic         rst_n,
  sc_in_if.sink        in_ch,
  output logic         q_valid,
  output sc_pkg::cmd_t q_cmd,
  input  logic         q_ready
);

  sc_pkg::cmd_t   ent_r [sc_pkg::QDEPTH];
  sc_pkg::qaddr_t wr_ptr_r;
  sc_pkg::qaddr_t rd_ptr_r;
  sc_pkg::qcnt_t  cnt_r;
  sc_pkg::cmd_t   dec;
  logic           push;
  logic           pop;

  always_comb begin
    dec.operand = in_ch.operand;
    dec.op      = sc_pkg::OP_ADD;
    case (sc_pkg::action_t'(in_ch.action))
      sc_pkg::ACT_PUSH: dec.kind = sc_pkg::K_PUSH;
      sc_pkg::ACT_POP:  dec.kind = sc_pkg::K_POP;
      sc_pkg::ACT_ADD: begin
        dec.kind = sc_pkg::K_ARITH;
        dec.op   = sc_pkg::OP_ADD;
      end
      sc_pkg::ACT_SUB: begin
        dec.kind = sc_pkg::K_ARITH;
        dec.op   = sc_pkg::OP_SUB;
      end
      sc_pkg::ACT_DIV: begin
        dec.kind = sc_pkg::K_ARITH;
        dec.op   = sc_pkg::OP_DIV;
      end
      sc_pkg::ACT_MUL: begin
        dec.kind = sc_pkg::K_ARITH;
        dec.op   = sc_pkg::OP_MUL;
      end
      sc_pkg::ACT_PEEK: dec.kind = sc_pkg::K_PEEK;
      sc_pkg::ACT_DUMP: dec.kind = sc_pkg::K_DUMP;
      default:          dec.kind = sc_pkg::K_DUMP;
    endcase
  end

  assign in_ch.ready = (cnt_r != sc_pkg::qcnt_t'(sc_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd = ent_r[rd_ptr_r];
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> rtl/core/sc_back.sv
module sc_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  sc_pkg::cmd_t q_cmd,
  output logic         q_ready,
  sc_out_if.source     out_ch
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_POP  = 8'b00000010,
    S_PEEK = 8'b00000100,
    S_RDB  = 8'b00001000,
    S_RDA  = 8'b00010000,
    S_DIV  = 8'b00100000,
    S_WB   = 8'b01000000,
    S_DUMP = 8'b10000000
  } state_t;

  state_t        state_r, state_nxt;
  sc_pkg::cnt_t  cnt_r, cnt_nxt;
  sc_pkg::cmd_t  cmd_r, cmd_nxt;
  sc_pkg::data_t b_r, b_nxt;
  sc_pkg::data_t res_r, res_nxt;
  sc_pkg::addr_t idx_r, idx_nxt;

  logic          wr_en;
  sc_pkg::addr_t wr_addr;
  sc_pkg::data_t wr_data;
  logic          rd_en;
  sc_pkg::addr_t rd_addr;
  sc_pkg::data_t rd_data;

  logic          div_start;
  logic          div_done;
  sc_pkg::data_t div_quo;

  logic            out_valid_r;
  sc_pkg::status_t out_status_r;
  sc_pkg::data_t   out_value_r;
  sc_pkg::fill_t   out_fill_r;
  logic            out_last_r;

  logic            out_free;
  logic            emit;
  sc_pkg::status_t e_status;
  sc_pkg::data_t   e_value;
  sc_pkg::cnt_t    e_fill;
  logic            e_last;
  sc_pkg::cnt_t    cnt_m1;
  sc_pkg::cnt_t    cnt_m2;

  sc_ram #(
    .WIDTH (sc_pkg::DATA_W),
    .DEPTH (sc_pkg::DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (b_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_m1 = cnt_r - 1'b1;
  assign cnt_m2 = cnt_r - 2'd2;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    idx_nxt   = idx_r;
    q_ready   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[sc_pkg::ADDR_W-1:0];
    wr_data   = q_cmd.operand;
    rd_en     = 1'b0;
    rd_addr   = cnt_m1[sc_pkg::ADDR_W-1:0];
    div_start = 1'b0;
    emit      = 1'b0;
    e_status  = sc_pkg::ST_OK;
    e_value   = '0;
    e_fill    = cnt_r;
    e_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        // A command is taken only when the output slot can hold its result.
        q_ready = out_free;
        if (q_valid && out_free) begin
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            sc_pkg::K_PUSH: begin
              emit = 1'b1;
              if (cnt_r == sc_pkg::cnt_t'(sc_pkg::DEPTH)) begin
                e_status = sc_pkg::ST_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                e_fill  = cnt_r + 1'b1;
              end
            end
            sc_pkg::K_POP: begin
              if (cnt_r == '0) begin
                emit     = 1'b1;
                e_status = sc_pkg::ST_UNDERFLOW;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_POP;
              end
            end
            sc_pkg::K_ARITH: begin
              if (cnt_r < sc_pkg::cnt_t'(2)) begin
                emit     = 1'b1;
                e_status = sc_pkg::ST_UNDERFLOW;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_RDB;
              end
            end
            sc_pkg::K_PEEK: begin
              if (cnt_r == '0) begin
                emit     = 1'b1;
                e_status = sc_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_PEEK;
              end
            end
            sc_pkg::K_DUMP: begin
              if (cnt_r == '0) begin
                emit     = 1'b1;
                e_status = sc_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              emit     = 1'b1;
              e_status = sc_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          e_value   = rd_data;
          cnt_nxt   = cnt_m1;
          e_fill    = cnt_m1;
          state_nxt = S_IDLE;
        end
      end
      S_PEEK: begin
        if (out_free) begin
          emit      = 1'b1;
          e_value   = rd_data;
          state_nxt = S_IDLE;
        end
      end
      S_RDB: begin
        if (cmd_r.op == sc_pkg::OP_DIV && rd_data == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            e_status  = sc_pkg::ST_DIVZERO;
            state_nxt = S_IDLE;
          end
        end else begin
          b_nxt     = rd_data;
          rd_en     = 1'b1;
          rd_addr   = cnt_m2[sc_pkg::ADDR_W-1:0];
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        case (cmd_r.op)
          sc_pkg::OP_ADD: begin
            res_nxt   = rd_data + b_r;
            state_nxt = S_WB;
          end
          sc_pkg::OP_SUB: begin
            res_nxt   = rd_data - b_r;
            state_nxt = S_WB;
          end
          sc_pkg::OP_MUL: begin
            res_nxt   = rd_data * b_r;
            state_nxt = S_WB;
          end
          sc_pkg::OP_DIV: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
          default: state_nxt = S_WB;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_quo;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (out_free) begin
          wr_en     = 1'b1;
          wr_addr   = cnt_m2[sc_pkg::ADDR_W-1:0];
          wr_data   = res_r;
          cnt_nxt   = cnt_m1;
          emit      = 1'b1;
          e_value   = res_r;
          e_fill    = cnt_m1;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        // One entry per cycle while the output slot is free; the next read is issued as the current one leaves.
        if (out_free) begin
          emit    = 1'b1;
          e_value = rd_data;
          e_last  = (sc_pkg::cnt_t'(idx_r) == cnt_m1);
          if (e_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
    idx_r <= idx_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_value_r  <= e_value;
      out_fill_r   <= sc_pkg::fill_t'(e_fill);
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.fill_level   = out_fill_r;
  assign out_ch.last         = out_last_r;

endmodule

>>> rtl/core/stack_calculator.sv
// Postfix stack calculator on signed 32-bit values.
// in_ch carries one command per transfer (action, operand); out_ch returns
// the results with a status, the stack fill level and a last flag. Every
// command gives one result, except a dump of a non-empty stack, which gives
// one result per entry from bottom to top with last set on the top entry.
// Commands enter a two-entry queue, so in_ch keeps accepting while the
// execution unit works or the receiver stalls; a full queue drops ready.
// Push, overflow, underflow and empty results come straight from the idle
// state; pop and peek first read the top entry; add, subtract and multiply
// read the two top entries of the stack memory, compute and write back;
// divide runs the radix-2 divider in place of the compute step, and a zero
// divisor is reported after the first read. A dump reads the entries one
// after another. Items run one at a time through the execution unit.
// When out_ch stalls, the result waits in the output register and the
// execution unit holds. Reset empties the stack and the queue; the stack
// memory itself is not cleared, since only entries below the fill level
// are ever read.
module stack_calculator (
  input  logic     clk,
  input  logic     rst_n,
  sc_in_if.sink    in_ch,
  sc_out_if.source out_ch
);

  logic         q_valid;
  logic         q_ready;
  sc_pkg::cmd_t q_cmd;

  sc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready)
  );

  sc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != sc_pkg::ST_OK |-> out_ch.result_value == '0)
    else $error("error result carries a nonzero value");

  a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> out_ch.status == sc_pkg::ST_OK)
    else $error("a result before the last one has an error status");

  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_ready |=> q_valid && $stable(q_cmd))
    else $error("queued command lost while the execution unit was busy");
`endif

endmodule

>>> sim/tb_stack_calculator.sv
`timescale 1ns / 100ps

module tb_stack_calculator;
  import sc_pkg::*;

  localparam int          RANDOM_ITEMS = 480;
  localparam int          TAIL_CYCLES  = 64;
  localparam int unsigned LIMIT_CYCLES = 600000;

  localparam data_t MOST_NEG  = 32'h8000_0000;
  localparam data_t MOST_POS  = 32'h7fff_ffff;
  localparam data_t MINUS_ONE = 32'hffff_ffff;

  typedef struct {
    status_t status;
    data_t   value;
    fill_t   fill;
    logic    last;
  } calc_result_t;

  logic clk;
  logic rst_n;

  sc_in_if  cmd_ch ();
  sc_out_if res_ch ();

  stack_calculator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  // Shadow copy of the stack, updated when a command transfer happens.
  data_t        stack_mem [DEPTH];
  int unsigned  stack_depth;
  calc_result_t expected_results [$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned commands_sent;
  int unsigned results_checked;
  int unsigned dumps_sent;
  int unsigned error_statuses;
  bit          quiet_source;
  bit          quiet_sink;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s got 0x%08h, expected 0x%08h",
             cycle_count, what, got, want);
  endtask

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic data_t draw_operand();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return MINUS_ONE;
          3: return '0;
          default: return data_t'(1);
        endcase
      end
      1, 2: return data_t'($urandom_range(0, 200)) - data_t'(100);
      default: return data_t'($urandom());
    endcase
  endfunction

  function automatic data_t quotient_toward_zero(data_t num, data_t den);
    logic  neg_num;
    logic  neg_den;
    data_t mag_num;
    data_t mag_den;
    data_t quo;
    neg_num = num[DATA_W-1];
    neg_den = den[DATA_W-1];
    mag_num = neg_num ? -num : num;
    mag_den = neg_den ? -den : den;
    quo = mag_num / mag_den;
    return (neg_num ^ neg_den) ? -quo : quo;
  endfunction

  function automatic void expect_result(status_t st, data_t val, logic fin);
    calc_result_t res;
    res.status = st;
    res.value  = val;
    res.fill   = fill_t'(stack_depth);
    res.last   = fin;
    expected_results.push_back(res);
    if (st != ST_OK) begin
      error_statuses++;
    end
  endfunction

  function automatic void predict_command(action_t act, data_t opnd);
    data_t lhs;
    data_t rhs;
    data_t res;
    case (act)
      ACT_PUSH: begin
        if (stack_depth >= DEPTH) begin
          expect_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          stack_mem[stack_depth] = opnd;
          stack_depth++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      ACT_POP: begin
        if (stack_depth == 0) begin
          expect_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          stack_depth--;
          expect_result(ST_OK, stack_mem[stack_depth], 1'b1);
        end
      end
      ACT_PEEK: begin
        if (stack_depth == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          expect_result(ST_OK, stack_mem[stack_depth-1], 1'b1);
        end
      end
      ACT_DUMP: begin
        dumps_sent++;
        if (stack_depth == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < stack_depth; i++) begin
            expect_result(ST_OK, stack_mem[i], i + 1 == stack_depth);
          end
        end
      end
      default: begin
        if (stack_depth < 2) begin
          expect_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          rhs = stack_mem[stack_depth-1];
          lhs = stack_mem[stack_depth-2];
          if (act == ACT_DIV && rhs == '0) begin
            // Both operands stay on the stack.
            expect_result(ST_DIVZERO, '0, 1'b1);
          end else begin
            case (act)
              ACT_ADD: res = lhs + rhs;
              ACT_SUB: res = lhs - rhs;
              ACT_DIV: res = quotient_toward_zero(lhs, rhs);
              default: res = lhs * rhs;
            endcase
            stack_depth--;
            stack_mem[stack_depth-1] = res;
            expect_result(ST_OK, res, 1'b1);
          end
        end
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(action_t act, data_t opnd);
    int gap;
    gap = draw_wait(quiet_source);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid   = 1'b1;
    cmd_ch.action  = act;
    cmd_ch.operand = opnd;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_command(act, opnd);
    commands_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    cmd_ch.valid = 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_empty_stack();
    send_command(ACT_POP, draw_operand());
    send_command(ACT_ADD, draw_operand());
    send_command(ACT_SUB, draw_operand());
    send_command(ACT_DIV, draw_operand());
    send_command(ACT_MUL, draw_operand());
    send_command(ACT_PEEK, draw_operand());
    send_command(ACT_DUMP, draw_operand());
  endtask

  task automatic test_arith_corners();
    // The most negative value divided by minus one wraps onto itself.
    send_command(ACT_PUSH, MOST_NEG);
    send_command(ACT_PUSH, MINUS_ONE);
    send_command(ACT_DIV, '0);
    send_command(ACT_PUSH, '0);
    send_command(ACT_DIV, MINUS_ONE);
    send_command(ACT_POP, MOST_POS);
    send_command(ACT_PUSH, MOST_POS);
    send_command(ACT_ADD, MOST_NEG);
    // A single entry is not enough for an operation.
    send_command(ACT_SUB, '0);
    send_command(ACT_PEEK, '0);
    send_command(ACT_PUSH, MOST_POS);
    send_command(ACT_MUL, '0);
  endtask

  task automatic test_full_stack();
    while (stack_depth < DEPTH) begin
      send_command(ACT_PUSH, draw_operand());
    end
    hold_until_drained();
    send_command(ACT_PUSH, MOST_POS);
    send_command(ACT_DUMP, '0);
  endtask

  task automatic test_random_programs();
    int      pick;
    action_t act;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: begin quiet_source = 1'b1; quiet_sink = 1'b1; end
          1: begin quiet_source = 1'b1; quiet_sink = 1'b0; end
          2: begin quiet_source = 1'b0; quiet_sink = 1'b1; end
          default: begin quiet_source = 1'b0; quiet_sink = 1'b0; end
        endcase
      end
      pick = $urandom_range(0, 99);
      // Mostly well-formed programs that keep the stack in use, with some noise.
      if (pick < 8) begin
        act = action_t'($urandom_range(0, 7));
      end else if (stack_depth < 2) begin
        act = ACT_PUSH;
      end else if (stack_depth >= DEPTH - 1) begin
        if (pick < 25) begin
          act = ACT_PUSH;
        end else if (pick < 35) begin
          act = ACT_DUMP;
        end else begin
          act = action_t'($urandom_range(int'(ACT_ADD), int'(ACT_MUL)));
        end
      end else if (pick < 48) begin
        act = ACT_PUSH;
      end else if (pick < 80) begin
        act = action_t'($urandom_range(int'(ACT_ADD), int'(ACT_MUL)));
      end else if (pick < 87) begin
        act = ACT_POP;
      end else if (pick < 93) begin
        act = ACT_PEEK;
      end else begin
        act = ACT_DUMP;
      end
      send_command(act, draw_operand());
    end
    quiet_source = 1'b0;
    quiet_sink   = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_wait(quiet_sink);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    calc_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", res_ch.status, '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (res_ch.status !== want.status) begin
          report_mismatch("status", res_ch.status, want.status);
        end
        if (res_ch.result_value !== want.value) begin
          report_mismatch("result_value", res_ch.result_value, want.value);
        end
        if (res_ch.fill_level !== want.fill) begin
          report_mismatch("fill_level", res_ch.fill_level, want.fill);
        end
        if (res_ch.last !== want.last) begin
          report_mismatch("last", res_ch.last, want.last);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run did not finish within %0d cycles.", LIMIT_CYCLES);
    $display("stack_calculator verification failed");
    $finish;
  end

  initial begin : main_sequence
    rst_n          = 1'b0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.action  = ACT_PUSH;
    cmd_ch.operand = '0;
    stack_depth    = 0;
    quiet_source   = 1'b0;
    quiet_sink     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_stack();
    test_arith_corners();
    test_full_stack();
    test_random_programs();

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results still missing", '0, expected_results.size());
    end

    $display("Sent %0d commands (%0d dumps) with random gaps on both channels.",
             commands_sent, dumps_sent);
    $display("Checked %0d results, %0d of them error statuses; %0d mismatches.",
             results_checked, error_statuses, mismatches);
    if (mismatches == 0) begin
      $display("stack_calculator verification clean");
    end else begin
      $display("stack_calculator verification failed");
    end
    $finish;
  end

endmodule
